@@ hw/rtl/dtcc_pkg.sv @@
`timescale 1ns / 1ps

package dtcc_pkg;

    localparam int COORD_W     = 11;
    localparam int ZMAX_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [2:0] CMD_FILL  = 3'd0;
    localparam logic [2:0] CMD_BEGIN = 3'd1;
    localparam logic [2:0] CMD_POINT = 3'd2;
    localparam logic [2:0] CMD_RECT  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         glyph;
        logic [ZMAX_W-1:0]  depth;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
        logic               hit;
    } dtcc_job_t;

endpackage

@@ hw/rtl/dtcc_front.sv @@
`timescale 1ns / 1ps

module dtcc_front
    import dtcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128,
    parameter int DEPTH_BITS  = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   take,
    input  logic [2:0]             cmd,
    input  logic signed [11:0]     pos_x,
    input  logic signed [11:0]     pos_y,
    input  logic signed [8:0]      depth,
    input  logic [7:0]             rect_w,
    input  logic [7:0]             rect_h,
    input  logic [7:0]             glyph,
    output logic                   job_wr,
    output dtcc_job_t              job
);

    localparam int SPAN_W = 14;

    localparam logic [16:0] DMAX = 17'((1 << DEPTH_BITS) - 1);

    logic [8:0] width_reg;
    logic [7:0] height_reg;

    logic [COORD_W-1:0]       cols;
    logic [COORD_W-1:0]       rows;
    logic signed [SPAN_W-1:0] cols_s;
    logic signed [SPAN_W-1:0] rows_s;
    logic signed [SPAN_W-1:0] sx;
    logic signed [SPAN_W-1:0] sy;
    logic signed [SPAN_W-1:0] ew;
    logic signed [SPAN_W-1:0] eh;
    logic signed [SPAN_W-1:0] ex;
    logic signed [SPAN_W-1:0] ey;
    logic signed [SPAN_W-1:0] x_lo;
    logic signed [SPAN_W-1:0] x_hi;
    logic signed [SPAN_W-1:0] y_lo;
    logic signed [SPAN_W-1:0] y_hi;
    logic                     area;
    logic                     hit;
    logic [16:0]              zu;
    logic [16:0]              zs;
    logic                     keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd80;
            height_reg <= 8'd24;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[7:0];
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 9'd0)
            cols = COORD_W'(1);
        else if (COORD_W'(width_reg) > COORD_W'(MAX_COLUMNS))
            cols = COORD_W'(MAX_COLUMNS);
        else
            cols = COORD_W'(width_reg);

        if (height_reg == 8'd0)
            rows = COORD_W'(1);
        else if (COORD_W'(height_reg) > COORD_W'(MAX_ROWS))
            rows = COORD_W'(MAX_ROWS);
        else
            rows = COORD_W'(height_reg);

        cols_s = {{(SPAN_W-COORD_W){1'b0}}, cols};
        rows_s = {{(SPAN_W-COORD_W){1'b0}}, rows};
        sx     = {{(SPAN_W-12){pos_x[11]}}, pos_x};
        sy     = {{(SPAN_W-12){pos_y[11]}}, pos_y};

        if (cmd == CMD_RECT)
        begin
            ew = {{(SPAN_W-8){1'b0}}, rect_w};
            eh = {{(SPAN_W-8){1'b0}}, rect_h};
        end
        else
        begin
            ew = SPAN_W'(1);
            eh = SPAN_W'(1);
        end

        ex   = sx + ew;
        ey   = sy + eh;
        x_lo = sx[SPAN_W-1] ? '0 : sx;
        y_lo = sy[SPAN_W-1] ? '0 : sy;
        x_hi = (ex > cols_s) ? cols_s : ex;
        y_hi = (ey > rows_s) ? rows_s : ey;
        area = (x_lo < x_hi) && (y_lo < y_hi);
        hit  = !sx[SPAN_W-1] && (sx < cols_s) && !sy[SPAN_W-1] && (sy < rows_s);

        zu = {9'd0, depth[7:0]};
        zs = (zu > DMAX) ? DMAX : zu;

        job.glyph = glyph;
        job.depth = zs[ZMAX_W-1:0];
        job.x_lo  = x_lo[COORD_W-1:0];
        job.x_hi  = x_hi[COORD_W-1:0];
        job.y_lo  = y_lo[COORD_W-1:0];
        job.y_hi  = y_hi[COORD_W-1:0];
        job.hit   = hit;

        unique case (cmd)
            CMD_FILL:
            begin
                job.op = OP_FILL;
                keep   = 1'b1;
            end
            CMD_BEGIN:
            begin
                job.op = OP_CLEAR;
                keep   = 1'b1;
            end
            CMD_POINT, CMD_RECT:
            begin
                job.op = OP_DRAW;
                keep   = !depth[8] && area;
            end
            CMD_READ:
            begin
                job.op = OP_READ;
                keep   = 1'b1;
            end
            default:
            begin
                job.op = OP_FILL;
                keep   = 1'b0;
            end
        endcase
    end

    assign job_wr = take && keep;

endmodule

@@ hw/rtl/dtcc_queue.sv @@
`timescale 1ns / 1ps

module dtcc_queue
    import dtcc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  dtcc_job_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output dtcc_job_t rd_data,
    output logic      avail
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dtcc_job_t     slot_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   count_reg;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_next;
    logic [PW:0]   count_next;

    assign full    = (count_reg == (PW + 1)'(DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = slot_reg[rp_reg];

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wp_next    = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            count_next = count_next + (PW + 1)'(1);
        end
        if (rd_en)
        begin
            rp_next    = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            count_next = count_next - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wp_reg] <= wr_data;
    end

endmodule

@@ hw/rtl/dtcc_back.sv @@
`timescale 1ns / 1ps

module dtcc_back
    import dtcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128,
    parameter int DEPTH_BITS  = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_avail,
    input  dtcc_job_t  job_in,
    output logic       job_take,
    output logic       init_busy,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] cell_glyph,
    output logic [7:0] cell_depth,
    output logic       cell_in_range
);

    localparam int CB    = $clog2(MAX_COLUMNS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int AW    = CB + RB;
    localparam int CELLS = 1 << AW;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_DRAW  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_RWAIT = 3'd6;

    logic [7:0]            glyph_mem [CELLS];
    logic [DEPTH_BITS-1:0] depth_mem [CELLS];
    logic [7:0]            glyph_rd_reg;
    logic [DEPTH_BITS-1:0] depth_rd_reg;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    dtcc_job_t          job_reg;
    dtcc_job_t          job_next;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cx_next;
    logic [COORD_W-1:0] cy_reg;
    logic [COORD_W-1:0] cy_next;
    logic [AW-1:0]      sweep_reg;
    logic [AW-1:0]      sweep_next;
    logic               pend_reg;
    logic               pend_next;
    logic [AW-1:0]      pend_addr_reg;
    logic [AW-1:0]      pend_addr_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_glyph_reg;
    logic [7:0]         out_glyph_next;
    logic [7:0]         out_depth_reg;
    logic [7:0]         out_depth_next;
    logic               out_hit_reg;
    logic               out_hit_next;

    logic                  g_we;
    logic [AW-1:0]         g_waddr;
    logic [7:0]            g_wdata;
    logic [AW-1:0]         g_raddr;
    logic                  d_we;
    logic [AW-1:0]         d_waddr;
    logic [DEPTH_BITS-1:0] d_wdata;
    logic [AW-1:0]         d_raddr;
    logic [AW-1:0]         draw_addr;
    logic [AW-1:0]         read_addr;
    logic [ZMAX_W-1:0]     depth_wide;
    logic                  last_sweep;

    assign draw_addr  = {cy_reg[RB-1:0], cx_reg[CB-1:0]};
    assign read_addr  = {job_reg.y_lo[RB-1:0], job_reg.x_lo[CB-1:0]};
    assign depth_wide = ZMAX_W'(depth_rd_reg);
    assign last_sweep = &sweep_reg;
    assign g_raddr    = read_addr;
    assign d_raddr    = (state_reg == S_READ) ? read_addr : draw_addr;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        sweep_next     = sweep_reg;
        pend_next      = (state_reg == S_DRAW);
        pend_addr_next = draw_addr;
        out_valid_next = out_valid_reg;
        out_glyph_next = out_glyph_reg;
        out_depth_next = out_depth_reg;
        out_hit_next   = out_hit_reg;
        job_take       = 1'b0;
        g_we           = 1'b0;
        g_waddr        = sweep_reg;
        g_wdata        = '0;
        d_we           = 1'b0;
        d_waddr        = sweep_reg;
        d_wdata        = '0;

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                g_we       = 1'b1;
                d_we       = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (last_sweep)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (job_avail)
                begin
                    job_take = 1'b1;
                    job_next = job_in;
                    cx_next  = job_in.x_lo;
                    cy_next  = job_in.y_lo;
                    unique case (job_in.op)
                        OP_FILL:  state_next = S_FILL;
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_DRAW:  state_next = S_DRAW;
                        OP_READ:  state_next = S_READ;
                    endcase
                end
            end
            S_FILL:
            begin
                g_we       = 1'b1;
                g_wdata    = job_reg.glyph;
                sweep_next = sweep_reg + AW'(1);
                if (last_sweep)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                d_we       = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (last_sweep)
                    state_next = S_IDLE;
            end
            S_DRAW:
            begin
                if (cx_reg + COORD_W'(1) == job_reg.x_hi)
                begin
                    cx_next = job_reg.x_lo;
                    cy_next = cy_reg + COORD_W'(1);
                    if (cy_reg + COORD_W'(1) == job_reg.y_hi)
                        state_next = S_IDLE;
                end
                else
                    cx_next = cx_reg + COORD_W'(1);
            end
            S_READ:
            begin
                if (!out_valid_reg)
                begin
                    if (job_reg.hit)
                        state_next = S_RWAIT;
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_glyph_next = '0;
                        out_depth_next = '0;
                        out_hit_next   = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_RWAIT:
            begin
                out_valid_next = 1'b1;
                out_glyph_next = glyph_rd_reg;
                out_depth_next = depth_wide[7:0];
                out_hit_next   = 1'b1;
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // write back the cell read in the previous cycle where it passes the depth test
        if (pend_reg && (depth_rd_reg <= job_reg.depth[DEPTH_BITS-1:0]))
        begin
            g_we    = 1'b1;
            g_waddr = pend_addr_reg;
            g_wdata = job_reg.glyph;
            d_we    = 1'b1;
            d_waddr = pend_addr_reg;
            d_wdata = job_reg.depth[DEPTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        pend_addr_reg <= pend_addr_next;
        out_glyph_reg <= out_glyph_next;
        out_depth_reg <= out_depth_next;
        out_hit_reg   <= out_hit_next;
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            glyph_mem[g_waddr] <= g_wdata;
        glyph_rd_reg <= glyph_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            depth_mem[d_waddr] <= d_wdata;
        depth_rd_reg <= depth_mem[d_raddr];
    end

    assign init_busy     = (state_reg == S_INIT);
    assign empty         = !out_valid_reg;
    assign cell_glyph    = out_glyph_reg;
    assign cell_depth    = out_depth_reg;
    assign cell_in_range = out_hit_reg;

endmodule

@@ hw/rtl/depth_tested_cell_compositor.sv @@
`timescale 1ns / 1ps
// channel   direction  beat taken when      payload
// config    in         cfg_we               cfg_index, cfg_data
// items     in         push && !full        cmd, pos_x, pos_y, depth, rect_w, rect_h, glyph
// results   out        pop && !empty        cell_glyph, cell_depth, cell_in_range
//
// Point and rectangle draws step one cell a cycle over the clipped area through the
// depth read-compare-write loop. Fill and begin frame sweep one store entry a cycle
// over all 2^(log2 cols + log2 rows) entries, 32768 at the default size.
// After reset a clearing pass over every store entry holds full high.
// A four-entry job queue lets items arrive while the store is busy; a read waits
// for the result register to be taken.

module depth_tested_cell_compositor
    import dtcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128,
    parameter int DEPTH_BITS  = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [2:0]             cmd,
    input  logic signed [11:0]     pos_x,
    input  logic signed [11:0]     pos_y,
    input  logic signed [8:0]      depth,
    input  logic [7:0]             rect_w,
    input  logic [7:0]             rect_h,
    input  logic [7:0]             glyph,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             cell_glyph,
    output logic [7:0]             cell_depth,
    output logic                   cell_in_range
);

    localparam int QUEUE_DEPTH = 4;

    logic      q_full;
    logic      q_wr;
    logic      q_rd;
    logic      q_avail;
    logic      init_busy;
    dtcc_job_t front_job;
    dtcc_job_t back_job;

    assign full = q_full || init_busy;

    dtcc_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (push && !full),
        .cmd       (cmd),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .depth     (depth),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .glyph     (glyph),
        .job_wr    (q_wr),
        .job       (front_job)
    );

    dtcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (front_job),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (back_job),
        .avail   (q_avail)
    );

    dtcc_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_avail     (q_avail),
        .job_in        (back_job),
        .job_take      (q_rd),
        .init_busy     (init_busy),
        .pop           (pop),
        .empty         (empty),
        .cell_glyph    (cell_glyph),
        .cell_depth    (cell_depth),
        .cell_in_range (cell_in_range)
    );

    a_no_take_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !q_rd)
        else $error("job taken during clearing pass");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_wr)
        else $error("job written into full queue");

    a_no_take_when_dry: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> q_avail)
        else $error("job taken from empty queue");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !cell_in_range) |-> (cell_glyph == 8'd0 && cell_depth == 8'd0))
        else $error("off-screen read beat carries data");

endmodule
